FILE: hw/rtl/kts_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kts_pkg
// Shared types and constants of the keyword token scanner: word formats,
// token codes, scan phases and character codes.
// ----------------------------------------------------------------------------
package kts_pkg;

  // lexeme length counter width and saturation value
  localparam int unsigned LenBits = 8;
  localparam logic [LenBits-1:0] LenMax = {LenBits{1'b1}};

  // identifier prefix kept for keyword matching
  localparam int unsigned PfxDepth = 5;
  localparam int unsigned PfxIdxW  = $clog2(PfxDepth);

  // result queue
  localparam int unsigned FifoDepth = 4;
  localparam int unsigned FifoPtrW  = $clog2(FifoDepth);
  localparam int unsigned FifoCntW  = $clog2(FifoDepth + 1);

  // character codes
  localparam logic [7:0] ChSemi   = 8'h3B;
  localparam logic [7:0] ChPlus   = 8'h2B;
  localparam logic [7:0] ChMinus  = 8'h2D;
  localparam logic [7:0] ChStar   = 8'h2A;
  localparam logic [7:0] ChSlash  = 8'h2F;
  localparam logic [7:0] ChLParen = 8'h28;
  localparam logic [7:0] ChRParen = 8'h29;
  localparam logic [7:0] ChLess   = 8'h3C;
  localparam logic [7:0] ChGreat  = 8'h3E;
  localparam logic [7:0] ChEqual  = 8'h3D;
  localparam logic [7:0] ChColon  = 8'h3A;
  localparam logic [7:0] ChSpace  = 8'h20;
  localparam logic [7:0] ChTab    = 8'h09;
  localparam logic [7:0] ChNewln  = 8'h0A;
  localparam logic [7:0] ChVTab   = 8'h0B;
  localparam logic [7:0] ChFFeed  = 8'h0C;
  localparam logic [7:0] ChCRet   = 8'h0D;

  // token codes
  typedef enum logic [4:0] {
    TkEoi       = 5'd0,
    TkSemi      = 5'd1,
    TkPlus      = 5'd2,
    TkMinus     = 5'd3,
    TkStar      = 5'd4,
    TkSlash     = 5'd5,
    TkLParen    = 5'd6,
    TkRParen    = 5'd7,
    TkLess      = 5'd8,
    TkGreat     = 5'd9,
    TkEqual     = 5'd10,
    TkNumId     = 5'd11,
    TkIf        = 5'd12,
    TkThen      = 5'd13,
    TkWhile     = 5'd14,
    TkDo        = 5'd15,
    TkBegin     = 5'd16,
    TkEnd       = 5'd17,
    TkAssign    = 5'd18,
    TkBad       = 5'd19,
    TkAssignErr = 5'd20
  } tok_kind_e;

  // scan phases
  typedef enum logic [2:0] {
    PhIdle  = 3'd0,
    PhNum   = 3'd1,
    PhId    = 3'd2,
    PhGap   = 3'd3,
    PhColon = 3'd4
  } scan_phase_e;

  // input word
  typedef struct packed {
    logic [7:0] symbol;
    logic       end_of_input;
  } in_word_t;

  // result word
  typedef struct packed {
    tok_kind_e          token_kind;
    logic [LenBits-1:0] lexeme_length;
    logic               last_of_run;
  } out_word_t;

  typedef logic [PfxDepth-1:0][7:0] pfx_arr_t;

  // scanner state update and tokens from one input word
  typedef struct packed {
    scan_phase_e        phase;
    logic [LenBits-1:0] run_len;
    logic               pfx_we;
    logic [PfxIdxW-1:0] pfx_idx;
    logic [7:0]         pfx_char;
    logic               tok_a_vld;
    out_word_t          tok_a;
    logic               tok_b_vld;
    out_word_t          tok_b;
  } scan_upd_t;

endpackage
`default_nettype wire

FILE: hw/rtl/kts_scan_step.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kts_scan_step
// Combinational scan of one character against the current scan phase:
// classifies the character, matches keywords and builds up to two tokens.
// ----------------------------------------------------------------------------
module kts_scan_step
  import kts_pkg::*;
(
  input  scan_phase_e        phase_i,
  input  logic [LenBits-1:0] run_len_i,
  input  pfx_arr_t           prefix_i,
  input  in_word_t           word_i,
  output scan_upd_t          upd_o
);

  // keyword lookup on stored prefix and length
  function automatic tok_kind_e kw_lookup(input pfx_arr_t p, input logic [LenBits-1:0] n);
    tok_kind_e k;
    k = TkNumId;
    if (n == LenBits'(2) && p[0] == "i" && p[1] == "f") begin
      k = TkIf;
    end else if (n == LenBits'(4) && p[0] == "t" && p[1] == "h" && p[2] == "e"
                 && p[3] == "n") begin
      k = TkThen;
    end else if (n == LenBits'(5) && p[0] == "w" && p[1] == "h" && p[2] == "i"
                 && p[3] == "l" && p[4] == "e") begin
      k = TkWhile;
    end else if (n == LenBits'(2) && p[0] == "d" && p[1] == "o") begin
      k = TkDo;
    end else if (n == LenBits'(5) && p[0] == "b" && p[1] == "e" && p[2] == "g"
                 && p[3] == "i" && p[4] == "n") begin
      k = TkBegin;
    end else if (n == LenBits'(3) && p[0] == "e" && p[1] == "n" && p[2] == "d") begin
      k = TkEnd;
    end
    return k;
  endfunction

  logic [7:0]         c;
  logic               is_digit;
  logic               is_letter;
  logic               is_gap;
  logic               is_idle_blank;
  logic               is_op;
  tok_kind_e          op_kind;
  tok_kind_e          kw_kind;
  logic               kw_ok;
  logic [LenBits-1:0] run_grow;
  logic               f_vld;
  out_word_t          f_tok;
  logic               s_vld;
  out_word_t          s_tok;
  logic               do_idle;
  scan_upd_t          upd;

  // character classes
  assign c             = word_i.symbol;
  assign is_digit      = (c >= "0") && (c <= "9");
  assign is_letter     = ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
  assign is_gap        = (c == ChSpace) || (c == ChTab) || (c == ChVTab) ||
                         (c == ChFFeed) || (c == ChCRet);
  assign is_idle_blank = (c == ChSpace) || (c == ChTab) || (c == ChNewln);
  assign kw_kind       = kw_lookup(prefix_i, run_len_i);
  assign kw_ok         = (kw_kind != TkNumId);
  assign run_grow      = (run_len_i == LenMax) ? run_len_i : run_len_i + LenBits'(1);

  // single-character operators
  always_comb begin
    is_op   = 1'b1;
    op_kind = TkSemi;
    unique case (c)
      ChSemi:   op_kind = TkSemi;
      ChPlus:   op_kind = TkPlus;
      ChMinus:  op_kind = TkMinus;
      ChStar:   op_kind = TkStar;
      ChSlash:  op_kind = TkSlash;
      ChLParen: op_kind = TkLParen;
      ChRParen: op_kind = TkRParen;
      ChLess:   op_kind = TkLess;
      ChGreat:  op_kind = TkGreat;
      ChEqual:  op_kind = TkEqual;
      default:  is_op   = 1'b0;
    endcase
  end

  // phase transition and token build
  always_comb begin
    upd          = '0;
    upd.phase    = phase_i;
    upd.run_len  = run_len_i;
    upd.pfx_char = c;
    f_vld        = 1'b0;
    f_tok        = '0;
    s_vld        = 1'b0;
    s_tok        = '0;
    do_idle      = 1'b0;

    if (word_i.end_of_input) begin
      // flush pending lexeme, then end of input
      f_tok.lexeme_length = run_len_i;
      unique case (phase_i)
        PhNum, PhGap: begin
          f_vld            = 1'b1;
          f_tok.token_kind = TkNumId;
        end
        PhId: begin
          f_vld            = 1'b1;
          f_tok.token_kind = kw_kind;
        end
        PhColon: begin
          f_vld            = 1'b1;
          f_tok.token_kind = TkAssignErr;
        end
        default: f_vld = 1'b0;
      endcase
      s_vld            = 1'b1;
      s_tok.token_kind = TkEoi;
      upd.phase        = PhIdle;
      upd.run_len      = '0;
    end else begin
      f_tok.lexeme_length = run_len_i;
      unique case (phase_i)
        PhNum: begin
          if (is_digit) begin
            upd.run_len = run_grow;
          end else begin
            f_vld            = 1'b1;
            f_tok.token_kind = TkNumId;
            do_idle          = 1'b1;
          end
        end
        PhId: begin
          if (is_digit || is_letter) begin
            upd.pfx_we  = (run_len_i < LenBits'(PfxDepth));
            upd.pfx_idx = run_len_i[PfxIdxW-1:0];
            upd.run_len = run_grow;
          end else if (kw_ok) begin
            f_vld            = 1'b1;
            f_tok.token_kind = kw_kind;
            do_idle          = 1'b1;
          end else if (c == ChColon) begin
            upd.phase = PhColon;
          end else if (is_gap) begin
            upd.phase = PhGap;
          end else begin
            f_vld            = 1'b1;
            f_tok.token_kind = TkNumId;
            do_idle          = 1'b1;
          end
        end
        PhGap: begin
          if (c == ChColon) begin
            upd.phase = PhColon;
          end else if (!is_gap) begin
            f_vld            = 1'b1;
            f_tok.token_kind = TkNumId;
            do_idle          = 1'b1;
          end
        end
        PhColon: begin
          f_vld = 1'b1;
          if (c == ChEqual) begin
            f_tok.token_kind = TkAssign;
            upd.phase        = PhIdle;
          end else begin
            f_tok.token_kind = TkAssignErr;
            do_idle          = 1'b1;
          end
        end
        default: do_idle = 1'b1;
      endcase

      // fresh scan of the character from idle
      if (do_idle) begin
        upd.phase           = PhIdle;
        s_tok.lexeme_length = LenBits'(1);
        priority if (is_op) begin
          s_vld            = 1'b1;
          s_tok.token_kind = op_kind;
        end else if (is_idle_blank) begin
          s_vld = 1'b0;
        end else if (is_digit) begin
          upd.phase   = PhNum;
          upd.run_len = LenBits'(1);
        end else if (is_letter) begin
          upd.phase   = PhId;
          upd.run_len = LenBits'(1);
          upd.pfx_we  = 1'b1;
          upd.pfx_idx = '0;
        end else begin
          s_vld            = 1'b1;
          s_tok.token_kind = TkBad;
        end
      end
    end

    // pack tokens in order, mark the last one
    upd.tok_a_vld         = f_vld || s_vld;
    upd.tok_a             = f_vld ? f_tok : s_tok;
    upd.tok_b_vld         = f_vld && s_vld;
    upd.tok_b             = s_tok;
    upd.tok_a.last_of_run = !(f_vld && s_vld);
    upd.tok_b.last_of_run = 1'b1;
  end

  assign upd_o = upd;

endmodule
`default_nettype wire

FILE: hw/rtl/kts_token_fifo.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kts_token_fifo
// Small result queue that takes up to two tokens per cycle and hands out one
// token per cycle on the output channel while the receiver is ready.
// ----------------------------------------------------------------------------
module kts_token_fifo
  import kts_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_a_i,
  input  out_word_t           word_a_i,
  input  logic                push_b_i,
  input  out_word_t           word_b_i,
  output logic                room2_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output out_word_t           out_data_o
);

  out_word_t [FifoDepth-1:0] mem_q;
  logic [FifoPtrW-1:0]       head_q, head_d;
  logic [FifoPtrW-1:0]       tail_q, tail_d;
  logic [FifoCntW-1:0]       count_q, count_d;
  logic                      pop;
  logic [FifoPtrW-1:0]       tail_p1;

  assign pop         = out_valid_o && out_ready_i;
  assign out_valid_o = (count_q != '0);
  assign out_data_o  = mem_q[head_q];
  assign room2_o     = (count_q <= FifoCntW'(FifoDepth - 2));
  assign tail_p1     = tail_q + FifoPtrW'(1);

  // pointer and fill count update
  always_comb begin
    head_d  = pop ? head_q + FifoPtrW'(1) : head_q;
    tail_d  = tail_q + FifoPtrW'(push_a_i) + FifoPtrW'(push_b_i);
    count_d = count_q + FifoCntW'(push_a_i) + FifoCntW'(push_b_i) - FifoCntW'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      tail_q  <= '0;
      count_q <= '0;
    end else begin
      head_q  <= head_d;
      tail_q  <= tail_d;
      count_q <= count_d;
    end
  end

  // storage, no reset needed
  always_ff @(posedge clk_i) begin
    if (push_a_i) begin
      mem_q[tail_q] <= word_a_i;
    end
    if (push_b_i) begin
      mem_q[tail_p1] <= word_b_i;
    end
  end

`ifndef SYNTH
  // fill count stays within the queue
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= FifoCntW'(FifoDepth))
    else $error("token queue overflow");

  // head and tail agree with the fill count
  a_ptr_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (tail_q - head_q) == count_q[FifoPtrW-1:0])
    else $error("token queue pointers out of step");

  // second slot is only written together with the first
  a_push_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_b_i |-> push_a_i)
    else $error("token queue second push without first");
`endif

endmodule
`default_nettype wire

FILE: hw/rtl/keyword_token_scanner_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// keyword_token_scanner_core
// Lexical scanner: one character word in, number, identifier, keyword,
// operator, assignment and error tokens out.
// ----------------------------------------------------------------------------
// The scanner takes one character word per cycle. A word sits in the input
// register, is scanned there against the scan phase, and its tokens (none,
// one or two) enter a four-entry result queue, from which they are offered
// on the output. The queue sets the rate: a word is taken from the input
// register only while two queue slots are free, so words that give one token
// or none flow at one per cycle, while the tokens of a word that gives two
// leave the queue one at a time on the output.
// ----------------------------------------------------------------------------
module keyword_token_scanner_core
  import kts_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_word_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_word_t out_data_o
);

  logic               in_valid_q;
  in_word_t           in_word_q;
  scan_phase_e        phase_q;
  logic [LenBits-1:0] run_len_q;
  pfx_arr_t           prefix_q;
  scan_upd_t          upd;
  logic               room2;
  logic               step;

  // input register
  assign step       = in_valid_q && room2;
  assign in_ready_o = !in_valid_q || step;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_word_q <= in_data_i;
    end
  end

  // scan of the registered word
  kts_scan_step u_step (
    .phase_i   (phase_q),
    .run_len_i (run_len_q),
    .prefix_i  (prefix_q),
    .word_i    (in_word_q),
    .upd_o     (upd)
  );

  // scanner state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PhIdle;
      run_len_q <= '0;
    end else if (step) begin
      phase_q   <= upd.phase;
      run_len_q <= upd.run_len;
    end
  end

  // identifier prefix, written as characters arrive
  always_ff @(posedge clk_i) begin
    if (step && upd.pfx_we) begin
      prefix_q[upd.pfx_idx] <= upd.pfx_char;
    end
  end

  // result queue
  kts_token_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_a_i    (step && upd.tok_a_vld),
    .word_a_i    (upd.tok_a),
    .push_b_i    (step && upd.tok_b_vld),
    .word_b_i    (upd.tok_b),
    .room2_o     (room2),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

`ifndef SYNTH
  // a lexeme in progress always has a non-zero length
  a_run_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PhNum || phase_q == PhId || phase_q == PhGap || phase_q == PhColon)
      |-> (run_len_q != '0))
    else $error("pending lexeme with zero length");

  // end of input leaves the scanner idle and cleared
  a_eoi_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step && in_word_q.end_of_input) |=> (phase_q == PhIdle && run_len_q == '0))
    else $error("scanner not idle after end of input");

  // end of input always yields a final end-of-input token
  a_eoi_token: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step && in_word_q.end_of_input) |->
      ((upd.tok_b_vld && upd.tok_b.token_kind == TkEoi) ||
       (!upd.tok_b_vld && upd.tok_a_vld && upd.tok_a.token_kind == TkEoi
        && upd.tok_a.last_of_run)))
    else $error("end of input without end token");
`endif

endmodule
`default_nettype wire

FILE: tb/keyword_token_scanner_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keyword_token_scanner_core_tb
// Self-checking bench for the keyword token scanner. Character words are
// queued up front, driven with random gaps and scored against a cycle-free
// scanner model that runs on every accepted word; token words are compared
// field by field in arrival order while the receiver stalls at random.
// ----------------------------------------------------------------------------
module keyword_token_scanner_core_tb;
  import kts_pkg::*;

  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned WordTarget = 1900;
  localparam int unsigned MaxReports = 10;
  localparam int unsigned DrainWait  = 12;

  // character classes
  localparam logic [7:0] ChZero = 8'h30;
  localparam logic [7:0] ChNine = 8'h39;
  localparam logic [7:0] ChLowA = 8'h61;
  localparam logic [7:0] ChLowZ = 8'h7A;
  localparam logic [7:0] ChUpA  = 8'h41;
  localparam logic [7:0] ChUpZ  = 8'h5A;

  logic      clk_i       = 1'b0;
  logic      rst_ni      = 1'b0;
  logic      in_valid_i  = 1'b0;
  logic      in_ready_o;
  in_word_t  in_data_i   = '0;
  logic      out_valid_o;
  logic      out_ready_i = 1'b0;
  out_word_t out_data_o;

  keyword_token_scanner_core uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  // clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // pending character words and expected token words
  in_word_t  char_q[$];
  out_word_t tok_expect_q[$];
  out_word_t step_toks[$];

  int unsigned words_total;
  int unsigned words_taken;
  int unsigned words_counted;
  int unsigned bad_words;
  int unsigned cycle_cnt;

  // scanner state as predicted
  scan_phase_e        lex_phase;
  logic [LenBits-1:0] lex_len;
  logic [7:0]         lex_pfx [PfxDepth];

  string     kw_text [6] = '{"if", "then", "while", "do", "begin", "end"};
  tok_kind_e kw_tok  [6] = '{TkIf, TkThen, TkWhile, TkDo, TkBegin, TkEnd};
  string     near_kw [12] = '{"iff", "the", "whiles", "d", "beg", "ends", "End", "IF",
                              "en", "thenx", "doo", "Begin"};

  function automatic bit is_digit(input logic [7:0] c);
    return c >= ChZero && c <= ChNine;
  endfunction

  function automatic bit is_letter(input logic [7:0] c);
    return (c >= ChLowA && c <= ChLowZ) || (c >= ChUpA && c <= ChUpZ);
  endfunction

  function automatic bit is_gap_blank(input logic [7:0] c);
    return c == ChSpace || c == ChTab || c == ChVTab || c == ChFFeed || c == ChCRet;
  endfunction

  // operator token of a character, bad-character code if none
  function automatic tok_kind_e op_token(input logic [7:0] c);
    case (c)
      ChSemi:   return TkSemi;
      ChPlus:   return TkPlus;
      ChMinus:  return TkMinus;
      ChStar:   return TkStar;
      ChSlash:  return TkSlash;
      ChLParen: return TkLParen;
      ChRParen: return TkRParen;
      ChLess:   return TkLess;
      ChGreat:  return TkGreat;
      ChEqual:  return TkEqual;
      default:  return TkBad;
    endcase
  endfunction

  // keyword lookup on saturated length and stored prefix
  function automatic tok_kind_e match_kw();
    bit hit;
    foreach (kw_text[k]) begin
      if (int'(lex_len) == kw_text[k].len()) begin
        hit = 1'b1;
        for (int i = 0; i < kw_text[k].len(); i++)
          if (lex_pfx[i] != kw_text[k][i]) hit = 1'b0;
        if (hit) return kw_tok[k];
      end
    end
    return TkNumId;
  endfunction

  task automatic push_tok(input tok_kind_e k, input logic [LenBits-1:0] len);
    out_word_t t;
    if (step_toks.size() < 2) begin
      t.token_kind    = k;
      t.lexeme_length = len;
      t.last_of_run   = 1'b0;
      step_toks.push_back(t);
    end
  endtask

  task automatic grow_len();
    if (lex_len != LenMax) lex_len = lex_len + 1'b1;
  endtask

  // a character seen between lexemes
  task automatic scan_fresh(input logic [7:0] c);
    tok_kind_e op;
    op = op_token(c);
    lex_phase = PhIdle;
    if (op != TkBad) begin
      push_tok(op, LenBits'(1));
    end else if (is_digit(c)) begin
      lex_phase = PhNum;
      lex_len   = LenBits'(1);
    end else if (is_letter(c)) begin
      lex_phase  = PhId;
      lex_len    = LenBits'(1);
      lex_pfx[0] = c;
    end else if (!(c == ChSpace || c == ChTab || c == ChNewln)) begin
      push_tok(TkBad, LenBits'(1));
    end
  endtask

  // close whatever lexeme is open
  task automatic flush_lexeme();
    case (lex_phase)
      PhNum, PhGap: push_tok(TkNumId, lex_len);
      PhId:         push_tok(match_kw(), lex_len);
      PhColon:      push_tok(TkAssignErr, lex_len);
      default: ;
    endcase
    lex_phase = PhIdle;
  endtask

  // expected token words of one accepted character word
  task automatic predict_tokens(input in_word_t w);
    logic [7:0] c;
    tok_kind_e  kw;
    c = w.symbol;
    step_toks.delete();
    if (w.end_of_input) begin
      flush_lexeme();
      push_tok(TkEoi, '0);
      lex_len = '0;
    end else begin
      case (lex_phase)
        PhNum: begin
          if (is_digit(c)) begin
            grow_len();
          end else begin
            flush_lexeme();
            scan_fresh(c);
          end
        end
        PhId: begin
          if (is_digit(c) || is_letter(c)) begin
            if (lex_len < PfxDepth) lex_pfx[int'(lex_len)] = c;
            grow_len();
          end else begin
            kw = match_kw();
            if (kw != TkNumId) begin
              push_tok(kw, lex_len);
              scan_fresh(c);
            end else if (c == ChColon) begin
              lex_phase = PhColon;
            end else if (is_gap_blank(c)) begin
              lex_phase = PhGap;
            end else begin
              push_tok(TkNumId, lex_len);
              scan_fresh(c);
            end
          end
        end
        PhGap: begin
          if (c == ChColon) begin
            lex_phase = PhColon;
          end else if (!is_gap_blank(c)) begin
            push_tok(TkNumId, lex_len);
            scan_fresh(c);
          end
        end
        PhColon: begin
          if (c == ChEqual) begin
            push_tok(TkAssign, lex_len);
            lex_phase = PhIdle;
          end else begin
            push_tok(TkAssignErr, lex_len);
            scan_fresh(c);
          end
        end
        default: scan_fresh(c);
      endcase
    end
    if (step_toks.size() > 0) step_toks[step_toks.size() - 1].last_of_run = 1'b1;
    foreach (step_toks[i]) tok_expect_q.push_back(step_toks[i]);
  endtask

  // idle percentage per side over the three thirds of the run
  function automatic int unsigned idle_pct(input bit sender);
    int unsigned third;
    third = (words_total == 0) ? 2 : (words_taken * 3) / words_total;
    case (third)
      0:       return sender ? 19 : 68;
      1:       return sender ? 68 : 19;
      default: return 0;
    endcase
  endfunction

  // stimulus helpers
  task automatic push_char(input logic [7:0] c);
    char_q.push_back('{symbol: c, end_of_input: 1'b0});
    words_counted++;
  endtask

  task automatic push_eoi();
    char_q.push_back('{symbol: 8'($urandom_range(0, 255)), end_of_input: 1'b1});
    words_counted++;
  endtask

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) push_char(s[i]);
  endtask

  function automatic logic [7:0] rand_letter();
    if ($urandom_range(0, 1)) return ChLowA + 8'($urandom_range(0, 25));
    return ChUpA + 8'($urandom_range(0, 25));
  endfunction

  task automatic push_digits(input int unsigned n);
    for (int unsigned i = 0; i < n; i++) push_char(ChZero + 8'($urandom_range(0, 9)));
  endtask

  task automatic push_ident(input int unsigned n);
    push_char(rand_letter());
    for (int unsigned i = 1; i < n; i++)
      push_char($urandom_range(0, 2) == 0 ? ChZero + 8'($urandom_range(0, 9))
                                          : rand_letter());
  endtask

  function automatic logic [7:0] rand_op();
    case ($urandom_range(0, 9))
      0:       return ChSemi;
      1:       return ChPlus;
      2:       return ChMinus;
      3:       return ChStar;
      4:       return ChSlash;
      5:       return ChLParen;
      6:       return ChRParen;
      7:       return ChLess;
      8:       return ChGreat;
      default: return ChEqual;
    endcase
  endfunction

  function automatic logic [7:0] rand_blank();
    case ($urandom_range(0, 5))
      0:       return ChSpace;
      1:       return ChTab;
      2:       return ChVTab;
      3:       return ChFFeed;
      4:       return ChCRet;
      default: return ChNewln;
    endcase
  endfunction

  task automatic push_gap();
    repeat ($urandom_range(0, 3)) push_char(rand_blank() == ChNewln ? ChSpace : rand_blank());
  endtask

  // what follows a lexeme
  task automatic push_tail();
    case ($urandom_range(0, 9))
      0, 1, 2: push_char(rand_blank());
      3, 4:    push_char(rand_op());
      5:       push_char(ChColon);
      6:       push_eoi();
      7:       push_char(8'($urandom_range(0, 255)));
      default: ;
    endcase
  endtask

  // sender
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_data_i  <= '0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        predict_tokens(in_data_i);
        words_taken++;
      end
      if (!in_valid_i || in_ready_o) begin
        if (char_q.size() > 0 && $urandom_range(0, 99) >= idle_pct(1'b1)) begin
          in_valid_i <= 1'b1;
          in_data_i  <= char_q.pop_front();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // receiver and token word check
  always @(posedge clk_i or negedge rst_ni) begin
    out_word_t exp_w;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (tok_expect_q.size() == 0) begin
          bad_words++;
          if (bad_words <= MaxReports)
            $display("unexpected token word: kind %0d len %0d last %0d",
                     out_data_o.token_kind, out_data_o.lexeme_length,
                     out_data_o.last_of_run);
        end else begin
          exp_w = tok_expect_q.pop_front();
          if (out_data_o.token_kind !== exp_w.token_kind ||
              out_data_o.lexeme_length !== exp_w.lexeme_length ||
              out_data_o.last_of_run !== exp_w.last_of_run) begin
            bad_words++;
            if (bad_words <= MaxReports)
              $display("token word mismatch: expected kind %0d len %0d last %0d,",
                       exp_w.token_kind, exp_w.lexeme_length, exp_w.last_of_run,
                       " got kind %0d len %0d last %0d",
                       out_data_o.token_kind, out_data_o.lexeme_length,
                       out_data_o.last_of_run);
          end
        end
      end
      out_ready_i <= ($urandom_range(0, 99) >= idle_pct(1'b0));
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CycleLimit) begin
      $display("keyword_token_scanner_core regression: fail");
      $finish;
    end
  end

  initial begin
    int unsigned long_done;
    int unsigned n;
    lex_phase     = PhIdle;
    lex_len       = '0;
    words_taken   = 0;
    words_counted = 0;
    bad_words     = 0;
    cycle_cnt     = 0;
    long_done     = 0;
    foreach (lex_pfx[i]) lex_pfx[i] = '0;

    // directed: operators, odd bytes, keyword then colon, gap assignment,
    // colon error, end of text with an open identifier
    push_text(";+-*/()<>=");
    push_char(8'h00);
    push_char(8'h7F);
    push_char(8'h80);
    push_char(8'hFF);
    push_char(ChColon);
    push_text("do:");
    push_char(ChLowA);
    push_char(ChTab);
    push_text(":=");
    push_text("x:y");
    push_eoi();

    // random lexeme stream with some noise and three long runs that can saturate
    while (words_counted < WordTarget) begin
      if (long_done < 3 && words_counted >= 400 + long_done * 500) begin
        n = $urandom_range(254, 300);
        case (long_done)
          0:       push_digits(n);
          1:       push_ident(n);
          default: push_ident(n);
        endcase
        if (long_done == 2) push_text(":=");
        else push_tail();
        long_done++;
      end
      case ($urandom_range(0, 99)) inside
        [0:14]: begin
          push_text(kw_text[$urandom_range(0, 5)]);
          push_tail();
        end
        [15:29]: begin
          if ($urandom_range(0, 3) == 0) push_text(near_kw[$urandom_range(0, 11)]);
          else push_ident($urandom_range(1, 7));
          push_tail();
        end
        [30:44]: begin
          if ($urandom_range(0, 4) == 0) push_text(near_kw[$urandom_range(0, 11)]);
          else push_ident($urandom_range(1, 7));
          push_gap();
          push_char(ChColon);
          push_gap();
          push_char(ChEqual);
        end
        [45:52]: begin
          push_ident($urandom_range(1, 6));
          push_gap();
          push_char(ChColon);
          if ($urandom_range(0, 3) == 0) push_eoi();
          else push_char($urandom_range(0, 1) ? rand_op() : 8'($urandom_range(0, 255)));
        end
        [53:65]: begin
          push_digits($urandom_range(1, 6));
          push_tail();
        end
        [66:75]: push_char(rand_op());
        [76:82]: push_char(rand_blank());
        [83:86]: push_eoi();
        default: push_char(8'($urandom_range(0, 255)));
      endcase
    end
    push_eoi();
    words_total = char_q.size();

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // drain
    while (char_q.size() != 0 || in_valid_i) @(posedge clk_i);
    while (tok_expect_q.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);

    if (bad_words == 0 && tok_expect_q.size() == 0) begin
      $display("keyword_token_scanner_core regression: pass");
    end else begin
      $display("keyword_token_scanner_core regression: fail");
    end
    $finish;
  end

endmodule
